/* rtl/core/csd_pkg.sv */
// shared types and constants for the cobs stream decoder
package csd_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte MAX_LENGTH_RST = 8'd254;
    localparam t_byte RUN_LAST       = 8'd1;
    localparam t_byte BYTE_ZERO      = 8'd0;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_END      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_ZERO     = 3'd3,
        ST_NOCODE   = 3'd4
    } t_status;

    typedef struct packed {
        logic  valid;
        t_byte in_byte;
    } t_in_beat;

    typedef struct packed {
        logic    out_valid;
        t_byte   out_byte;
        t_status status;
        t_byte   frame_length;
    } t_result;

    typedef struct packed {
        t_byte byte_count;
        t_byte run_left;
    } t_dec_state;

endpackage

/* rtl/core/csd_if.sv */
// valid/ready channel interfaces for encoded input beats and decoded result beats
interface csd_in_if;
    import csd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface csd_out_if;
    import csd_pkg::*;

    logic    valid;
    logic    ready;
    logic    out_valid;
    t_byte   out_byte;
    t_status status;
    t_byte   frame_length;

    modport source (output valid, output out_valid, output out_byte, output status,
                    output frame_length, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input status,
                    input frame_length, output ready);
endinterface

/* rtl/core/csd_in_stage.sv */
// input register holding one encoded byte ahead of the decoder
module csd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csd_in_if.sink            i_in,
    input  logic              i_adv,
    output csd_pkg::t_in_beat o_beat
);
    import csd_pkg::*;

    logic  r_valid;
    t_byte r_byte;

    // slot frees up when its beat moves on in the same cycle
    assign i_in.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.in_byte = r_byte;

endmodule

/* rtl/core/csd_decode.sv */
// run counter, byte counter, length limit and the per-byte decode logic
module csd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  csd_pkg::t_byte      i_cfg_data,
    input  csd_pkg::t_in_beat   i_beat,
    input  logic                i_adv,
    output csd_pkg::t_result    o_result,
    output csd_pkg::t_dec_state o_state
);
    import csd_pkg::*;

    t_byte   r_max_length;
    t_byte   r_byte_count;
    t_byte   r_run_left;
    t_byte   n_byte_count;
    t_byte   n_run_left;
    t_byte   b;
    t_result res;

    assign b = i_beat.in_byte;

    always_comb begin
        res.out_valid    = 1'b0;
        res.out_byte     = BYTE_ZERO;
        res.status       = ST_BUSY;
        res.frame_length = BYTE_ZERO;
        n_byte_count     = r_byte_count;
        n_run_left       = r_run_left;

        if (b == BYTE_ZERO) begin
            if (r_run_left == BYTE_ZERO) begin
                // zero between frames, nothing to do
            end else if (r_run_left == RUN_LAST) begin
                res.status       = ST_END;
                res.frame_length = r_byte_count;
                n_byte_count     = BYTE_ZERO;
                n_run_left       = BYTE_ZERO;
            end else begin
                res.status   = ST_ZERO;
                n_byte_count = BYTE_ZERO;
                n_run_left   = BYTE_ZERO;
            end
        end else if (r_byte_count == BYTE_ZERO && r_run_left == BYTE_ZERO) begin
            // first code of a frame
            n_run_left = b;
        end else if (r_run_left == BYTE_ZERO) begin
            res.status   = ST_NOCODE;
            n_byte_count = BYTE_ZERO;
            n_run_left   = BYTE_ZERO;
        end else if (r_byte_count >= r_max_length) begin
            res.status   = ST_OVERFLOW;
            n_byte_count = BYTE_ZERO;
            n_run_left   = BYTE_ZERO;
        end else begin
            res.out_valid = 1'b1;
            if (r_run_left == RUN_LAST) begin
                // run boundary: implied zero, this byte is the next code
                res.out_byte = BYTE_ZERO;
                n_run_left   = b;
            end else begin
                res.out_byte = b;
                n_run_left   = r_run_left - RUN_LAST;
            end
            n_byte_count = r_byte_count + RUN_LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= BYTE_ZERO;
            r_run_left   <= BYTE_ZERO;
        end else if (i_adv) begin
            r_byte_count <= n_byte_count;
            r_run_left   <= n_run_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

    assign o_result           = res;
    assign o_state.byte_count = r_byte_count;
    assign o_state.run_left   = r_run_left;

endmodule

/* rtl/core/csd_out_stage.sv */
// result register driving the decoded output channel
module csd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  csd_pkg::t_result i_result,
    csd_out_if.source        o_out,
    output logic             o_free
);
    import csd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_valid    = r_result.out_valid;
    assign o_out.out_byte     = r_result.out_byte;
    assign o_out.status       = r_result.status;
    assign o_out.frame_length = r_result.frame_length;

endmodule

/* rtl/core/cobs_stream_decoder_top.sv */
// top level of the cobs stream decoder
//
// i_in carries one encoded byte per beat; o_out returns exactly one result
// beat for every input beat, in order: a decoded byte flag and value, a
// status code (busy/idle, frame end, overflow, unexpected zero, missing
// code) and the frame length on a frame end.
// i_cfg_we/i_cfg_data write the frame length limit; write it only while
// no beat is in flight.
// a beat accepted into the input register is decoded combinationally and its
// result is loaded into the result register when the beat advances.
// throughput: one beat per cycle while o_out does not stall, set by the
// update of the run and byte counters in the decode stage.
// when o_out stalls, the result register and the input register fill and
// i_in.ready drops; nothing is lost. a result leaving frees a slot in the
// same cycle.
// reset (synchronous, active low) empties both registers, clears the
// counters to idle and sets the length limit to 254.
module cobs_stream_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  csd_pkg::t_byte i_cfg_data,
    csd_in_if.sink         i_in,
    csd_out_if.source      o_out
);
    import csd_pkg::*;

    t_in_beat   beat;
    t_result    result;
    t_dec_state dec_state;
    logic       out_free;
    logic       adv;

    assign adv = beat.valid && out_free;

    csd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_beat  (beat)
    );

    csd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_beat     (beat),
        .i_adv      (adv),
        .o_result   (result),
        .o_state    (dec_state)
    );

    csd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (result),
        .o_out    (o_out),
        .o_free   (out_free)
    );

    // any terminating status sends the counters back to idle
    a_idle_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && result.status != ST_BUSY) |=>
        (dec_state.run_left == BYTE_ZERO && dec_state.byte_count == BYTE_ZERO))
        else $error("decoder not idle after frame end or error");

    // counting only happens inside a run
    a_count_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_state.run_left == BYTE_ZERO) |-> (dec_state.byte_count == BYTE_ZERO))
        else $error("byte count set while idle");

    // both registers full and the receiver stalled: no new beat may enter
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat.valid && !out_free) |-> !i_in.ready)
        else $error("input accepted while pipeline full");

endmodule
